// ===== src/glmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_pkg: shared types and constants
// Widths, register indexes and controller/datapath handshake structs for the
// grid local maximum finder.
// ----------------------------------------------------------------------------
package glmf_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 32;
  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = 6;   // width of the count registers
  localparam int COL_W       = 5;
  localparam int ROW_W       = 5;
  localparam int BANK_N      = 3;
  localparam int BANK_W      = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_DATA_W  = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t OUTSIDE_VALUE = '1;  // -1 border padding

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] MAX_COLUMNS_CNT = CNT_W'(MAX_COLUMNS);
  localparam logic [CNT_W-1:0] MAX_ROWS_CNT    = CNT_W'(MAX_ROWS);

  // controller -> datapath
  typedef struct packed {
    logic accept;       // take the input word
    logic rd_centre;    // read centre and upper cell
    logic rd_right;     // read right-hand cell
    logic eval;         // compare and queue a peak
    logic flush_start;  // begin last-row sweep at column 0
    logic step_next;    // next column of the sweep
    logic finish;       // drain pending result, advance position
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_eval;      // incoming word decides a cell above it
    logic in_final;     // incoming word closes the grid
    logic cur_final;
    logic flush_mode;
    logic last_cell;    // column index is the last column
    logic eval_ok;
    logic finish_ok;
    logic pend_valid;
  } stat_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] res;
    res = v;
    if (v == '0) res = CNT_W'(1);
    else if (v > lim) res = lim;
    return res;
  endfunction

endpackage

// ===== src/grid_local_maximum_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_maximum_finder: four-neighbour peak finder over a raster grid
// Reports row and column of every cell that is >= its four neighbours, with
// cells outside the grid taken as -1. Results come out in raster order.
// ----------------------------------------------------------------------------
// Samples of a row_count x column_count grid enter in raster order, one word
// at a time; the cell above a sample is decided when that sample arrives, and
// the closing sample of a grid also sweeps the whole last row. A row-zero
// sample is accepted and finished; any other sample is accepted, then the
// middle row bank is read twice, then compare and finish; the closing sample
// adds a centre read, right read and compare per column of the sweep. These
// steps come from the single read port of each row bank, and a stalled
// result port stretches them. tlast marks the final result a sample produces.
// Any configuration write restarts the grid; write only while the block is idle.
module grid_local_maximum_finder
  import glmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,    // [15:0] sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [4:0] peak_row, [9:5] peak_column
  output logic                  out_tlast,   // last_of_run
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]      cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  glmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  glmf_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // no held-back result may be left over when a new word can be taken
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.pend_valid)
    else $error("pending result left behind at idle");

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word taken while one is in progress");

  // controller issues at most one datapath step per cycle
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.rd_centre, cmd.rd_right, cmd.eval, cmd.finish}))
    else $error("overlapping datapath commands");

  // sweep steps only happen during a last-row sweep
  a_step_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_next |-> (stat.flush_mode && !stat.last_cell))
    else $error("sweep step outside last-row sweep");
`endif

endmodule

// ===== src/glmf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_ctrl: sequencing state machine
// Steps each sample through write, centre and right reads, compare, finish
// (row zero: write, finish); runs the last-row sweep on the closing sample.
// ----------------------------------------------------------------------------
module glmf_ctrl
  import glmf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD_C = 3'd1;
  localparam logic [2:0] ST_RD_R = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = (stat.in_eval || stat.in_final) ? ST_RD_C : ST_FIN;
        end
      end
      ST_RD_C: begin
        cmd.rd_centre = 1'b1;
        state_nxt     = ST_RD_R;
      end
      ST_RD_R: begin
        cmd.rd_right = 1'b1;
        state_nxt    = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.eval_ok) begin
          cmd.eval = 1'b1;
          if (!stat.flush_mode) begin
            if (stat.cur_final) begin
              cmd.flush_start = 1'b1;
              state_nxt       = ST_RD_C;
            end else begin
              state_nxt = ST_FIN;
            end
          end else if (stat.last_cell) begin
            state_nxt = ST_FIN;
          end else begin
            cmd.step_next = 1'b1;
            state_nxt     = ST_RD_C;
          end
        end
      end
      ST_FIN: begin
        if (stat.finish_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/glmf_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_dpath: row banks, compare window and result register
// Three rotating row banks, the neighbour window, a one-deep pending result
// that lets the final result of a sample carry tlast, and the output word.
// ----------------------------------------------------------------------------
module glmf_dpath
  import glmf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic [SAMPLE_W-1:0]    in_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_wdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,
  output logic                   out_tlast
);

  // configuration and position
  logic [CNT_W-1:0] row_count_r, column_count_r;
  logic [CNT_W-1:0] rows, cols;
  logic [ROW_W-1:0] rows_m1;
  logic [COL_W-1:0] cols_m1;
  logic [ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [COL_W-1:0] col_pos_r, col_pos_nxt;
  logic [ROW_W-1:0] r_eff;
  logic [COL_W-1:0] c_eff;
  logic             pos_wrap;

  // current item
  sample_t          s_r;
  logic [ROW_W-1:0] cur_r_r;
  logic [COL_W-1:0] cur_c_r;
  logic             cur_final_r;
  logic             flush_mode_r;
  logic [COL_W-1:0] k_r;

  // bank roles
  logic [BANK_W-1:0] ptr_up_r, ptr_mid_r, ptr_low_r;
  logic [BANK_W-1:0] x_bank, a_bank, wr_bank;
  logic [COL_W-1:0]  x_addr;
  logic              wr_en;
  logic              rd_en;
  logic [SAMPLE_W-1:0] bank_q_r [BANK_N];
  sample_t           x_q, a_q;

  // window
  sample_t centre_r, up_r, left_r;
  sample_t left_v, right_v, up_v, down_v;
  logic    up_pad;
  logic    peak;
  logic [ROW_W-1:0] peak_row;

  // results
  logic             pend_valid_r;
  logic [ROW_W-1:0] pend_row_r;
  logic [COL_W-1:0] pend_col_r;
  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;
  logic             out_free;
  logic             push_eval, push_fin;

  assign rows    = eff_count(row_count_r, MAX_ROWS_CNT);
  assign cols    = eff_count(column_count_r, MAX_COLUMNS_CNT);
  assign rows_m1 = ROW_W'(rows - CNT_W'(1));
  assign cols_m1 = COL_W'(cols - CNT_W'(1));

  assign pos_wrap = ({1'b0, row_pos_r} >= rows) || ({1'b0, col_pos_r} >= cols);
  assign r_eff    = pos_wrap ? '0 : row_pos_r;
  assign c_eff    = pos_wrap ? '0 : col_pos_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= CNT_W'(1);
      column_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_COUNT:    row_count_r    <= cfg_wdata;
        REG_COLUMN_COUNT: column_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // position of the next sample
  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    if (cmd.finish) begin
      if (cur_final_r) begin
        row_pos_nxt = '0;
        col_pos_nxt = '0;
      end else if (cur_c_r == cols_m1) begin
        row_pos_nxt = cur_r_r + ROW_W'(1);
        col_pos_nxt = '0;
      end else begin
        row_pos_nxt = cur_r_r;
        col_pos_nxt = cur_c_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      ptr_up_r  <= BANK_W'(0);
      ptr_mid_r <= BANK_W'(1);
      ptr_low_r <= BANK_W'(2);
    end else if (cfg_we) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      // end of a row after row zero: middle moves up, lower moves to middle
      if (cmd.finish && !cur_final_r && cur_c_r == cols_m1 && cur_r_r != '0) begin
        ptr_up_r  <= ptr_mid_r;
        ptr_mid_r <= ptr_low_r;
        ptr_low_r <= ptr_up_r;
      end
    end
  end

  // item latch and sweep index
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r         <= sample_t'(in_tdata);
      cur_r_r     <= r_eff;
      cur_c_r     <= c_eff;
      cur_final_r <= (r_eff == rows_m1) && (c_eff == cols_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_mode_r <= 1'b0;
      k_r          <= '0;
    end else if (cmd.accept) begin
      flush_mode_r <= (r_eff == '0);
      k_r          <= (r_eff == '0) ? '0 : c_eff;
    end else if (cmd.flush_start) begin
      flush_mode_r <= 1'b1;
      k_r          <= '0;
    end else if (cmd.step_next) begin
      k_r <= k_r + COL_W'(1);
    end
  end

  // bank roles: deciding row r-1 reads middle/upper; the sweep reads
  // lower/middle, or middle alone for a one-row grid
  always_comb begin
    if (flush_mode_r && cur_r_r != '0) begin
      x_bank = ptr_low_r;
      a_bank = ptr_mid_r;
    end else begin
      x_bank = ptr_mid_r;
      a_bank = ptr_up_r;
    end
    up_pad  = flush_mode_r ? (cur_r_r == '0) : (cur_r_r == ROW_W'(1));
    wr_en   = cmd.accept;
    wr_bank = (r_eff == '0) ? ptr_mid_r : ptr_low_r;
    rd_en   = cmd.rd_centre || cmd.rd_right;
    x_addr  = cmd.rd_right ? (k_r + COL_W'(1)) : k_r;
  end

  for (genvar b = 0; b < BANK_N; b++) begin : g_bank
    logic [SAMPLE_W-1:0] bank_mem [MAX_COLUMNS];
    logic [COL_W-1:0]    raddr;
    assign raddr = (x_bank == BANK_W'(b)) ? x_addr : k_r;
    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == BANK_W'(b)) begin
        bank_mem[c_eff] <= in_tdata;
      end
      if (rd_en) begin
        bank_q_r[b] <= bank_mem[raddr];
      end
    end
  end

  always_comb begin
    case (x_bank)
      2'd1:    x_q = sample_t'(bank_q_r[1]);
      2'd2:    x_q = sample_t'(bank_q_r[2]);
      default: x_q = sample_t'(bank_q_r[0]);
    endcase
    case (a_bank)
      2'd1:    a_q = sample_t'(bank_q_r[1]);
      2'd2:    a_q = sample_t'(bank_q_r[2]);
      default: a_q = sample_t'(bank_q_r[0]);
    endcase
  end

  // neighbour window
  always_ff @(posedge clk) begin
    if (cmd.rd_right) begin
      centre_r <= x_q;
      up_r     <= a_q;
    end
    if (cmd.eval) begin
      left_r <= centre_r;
    end
  end

  always_comb begin
    left_v   = (k_r == '0) ? OUTSIDE_VALUE : left_r;
    right_v  = (k_r == cols_m1) ? OUTSIDE_VALUE : x_q;
    up_v     = up_pad ? OUTSIDE_VALUE : up_r;
    down_v   = flush_mode_r ? OUTSIDE_VALUE : s_r;
    peak     = (centre_r >= up_v) && (centre_r >= left_v) &&
               (centre_r >= down_v) && (centre_r >= right_v);
    peak_row = flush_mode_r ? cur_r_r : (cur_r_r - ROW_W'(1));
  end

  // a peak is held back one step so the last one of a sample gets tlast
  assign out_free  = !out_valid_r || out_tready;
  assign push_eval = cmd.eval && peak && pend_valid_r;
  assign push_fin  = cmd.finish && pend_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.eval && peak) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.finish) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && peak) begin
      pend_row_r <= peak_row;
      pend_col_r <= k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_eval || push_fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_eval || push_fin) begin
      out_row_r  <= pend_row_r;
      out_col_r  <= pend_col_r;
      out_last_r <= push_fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_DATA_W - COL_W - ROW_W)'(0), out_col_r, out_row_r};

  always_comb begin
    stat            = '0;
    stat.in_eval    = (r_eff != '0);
    stat.in_final   = (r_eff == rows_m1) && (c_eff == cols_m1);
    stat.cur_final  = cur_final_r;
    stat.flush_mode = flush_mode_r;
    stat.last_cell  = (k_r == cols_m1);
    stat.eval_ok    = !(peak && pend_valid_r) || out_free;
    stat.finish_ok  = !pend_valid_r || out_free;
    stat.pend_valid = pend_valid_r;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for grid_local_maximum_finder
// Streams grids of signed samples through the block under several row and
// column settings, predicts every four-neighbour peak in raster order and
// compares each result word against the oldest predicted peak. Both stream
// sides idle at random; one long output stall and one input drain are forced.
// ----------------------------------------------------------------------------
module testbench
  import glmf_pkg::*;
();

  localparam int SETTLE_CYCLES = 5 + 3 * MAX_COLUMNS + 40;  // one flush sweep and slack
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 16;
  localparam int MAX_PRINTS    = 40;

  typedef sample_t row_t [MAX_COLUMNS];

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } peak_t;

  typedef enum int {FILL_WIDE, FILL_NARROW, FILL_FLAT} fill_t;

  // Predicts peaks from accepted samples and holds them until they come out.
  class peak_tracker;
    row_t             upper, middle, lower;
    int               row_pos, col_pos;
    logic [CNT_W-1:0] row_reg, col_reg;
    peak_t            pending[$];
    int               mismatches;

    function new();
      row_reg = CNT_W'(1);
      col_reg = CNT_W'(1);
      foreach (middle[i]) begin
        middle[i] = '0;
        lower[i]  = '0;
      end
      mismatches = 0;
      restart();
    endfunction

    function int clamp_count(logic [CNT_W-1:0] v, int lim);
      if (v == '0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
    endfunction

    function int cells();
      return clamp_count(row_reg, MAX_ROWS) * clamp_count(col_reg, MAX_COLUMNS);
    endfunction

    function void restart();
      foreach (upper[i]) upper[i] = OUTSIDE_VALUE;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] value);
      if (idx == REG_ROW_COUNT) row_reg = value;
      else col_reg = value;
      restart();
    endfunction

    function bit dominates(sample_t centre, sample_t up, sample_t left, sample_t down,
                           sample_t right);
      return centre >= up && centre >= left && centre >= down && centre >= right;
    endfunction

    function peak_t make_peak(int r, int c);
      peak_t p;
      p.row  = ROW_W'(r);
      p.col  = COL_W'(c);
      p.last = 1'b0;
      return p;
    endfunction

    function void note_sample(sample_t s);
      int      rows, cols, r, c;
      sample_t left, right;
      row_t    bottom, above;
      peak_t   found[$];
      rows = clamp_count(row_reg, MAX_ROWS);
      cols = clamp_count(col_reg, MAX_COLUMNS);
      r = row_pos;
      c = col_pos;
      if (r >= rows || c >= cols) begin
        r = 0;
        c = 0;
      end
      if (r == 0) begin
        middle[c] = s;
      end else begin
        left  = (c > 0) ? middle[c-1] : OUTSIDE_VALUE;
        right = (c + 1 < cols) ? middle[c+1] : OUTSIDE_VALUE;
        lower[c] = s;
        if (dominates(middle[c], upper[c], left, s, right))
          found.push_back(make_peak(r - 1, c));
      end
      if (r == rows - 1 && c == cols - 1) begin
        // closing sample: sweep the whole last row
        if (r == 0) begin
          bottom = middle;
          above  = upper;
        end else begin
          bottom = lower;
          above  = middle;
        end
        for (int j = 0; j < cols; j++) begin
          left  = (j > 0) ? bottom[j-1] : OUTSIDE_VALUE;
          right = (j + 1 < cols) ? bottom[j+1] : OUTSIDE_VALUE;
          if (dominates(bottom[j], above[j], left, OUTSIDE_VALUE, right))
            found.push_back(make_peak(r, j));
        end
        restart();
      end else if (c == cols - 1) begin
        if (r >= 1) begin
          upper  = middle;
          middle = lower;
        end
        row_pos = r + 1;
        col_pos = 0;
      end else begin
        row_pos = r;
        col_pos = c + 1;
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) pending.push_back(found[i]);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_peak(logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic last);
      peak_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected peak row %0d col %0d", row, col));
        return;
      end
      want = pending.pop_front();
      if (row !== want.row)
        report($sformatf("peak_row %0d, want %0d", row, want.row));
      if (col !== want.col)
        report($sformatf("peak_column %0d, want %0d (row %0d)", col, want.col, want.row));
      if (last !== want.last)
        report($sformatf("tlast %b, want %b at row %0d col %0d", last, want.last,
                         want.row, want.col));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CNT_W-1:0]      cfg_wdata;

  peak_tracker      sb;
  logic [CNT_W-1:0] cur_rows, cur_cols;
  bit               gaps_on;
  bit               hold_req;
  int               sent;

  grid_local_maximum_finder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_peak(out_tdata[ROW_W-1:0], out_tdata[ROW_W+COL_W-1:ROW_W], out_tlast);
  end

  // All driving tasks start and end right after a falling edge.
  task automatic send_sample(input sample_t s);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
    sent++;
    @(negedge clk);
  endtask

  task automatic pause_feed(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_peaks();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending.size() != 0);
  endtask

  task automatic wait_idle();
    drain_peaks();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
    if (idx == REG_ROW_COUNT) cur_rows = value;
    else cur_cols = value;
    @(negedge clk);
  endtask

  task automatic set_grid(input logic [CNT_W-1:0] rows, input logic [CNT_W-1:0] cols);
    wait_idle();
    if ($urandom_range(0, 1)) begin
      write_count(REG_ROW_COUNT, rows);
      write_count(REG_COLUMN_COUNT, cols);
    end else begin
      write_count(REG_COLUMN_COUNT, cols);
      write_count(REG_ROW_COUNT, rows);
    end
  endtask

  task automatic send_grid(input int n, input fill_t fill, input sample_t level,
                           input int pause_at);
    sample_t s;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain_peaks();
      if (gaps_on && $urandom_range(0, 3) == 0) pause_feed($urandom_range(1, 14));
      case (fill)
        FILL_WIDE:   s = sample_t'($urandom);
        FILL_NARROW: s = sample_t'($urandom_range(0, 6) - 3);
        default:     s = level;
      endcase
      send_sample(s);
    end
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CNT_W'($urandom_range(33, 63));
      2:       return CNT_W'($urandom_range(7, 12));
      default: return CNT_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    logic [CNT_W-1:0] rows, cols;
    int               total, n, cnt;
    bit               cut;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_ROW_COUNT;
    cfg_wdata = '0;
    cur_rows  = CNT_W'(1);
    cur_cols  = CNT_W'(1);
    gaps_on   = 1'b1;
    hold_req  = 1'b0;
    sent      = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 1x1 grid after reset: most negative, most positive, tie with the border, zero
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(16'h7fff));
    send_sample(sample_t'(16'hffff));
    send_sample(sample_t'(16'h0000));

    // zero row count acts as one: a single row of three
    set_grid('0, CNT_W'(3));
    send_sample(sample_t'(5));
    send_sample(sample_t'(5));
    send_sample(sample_t'(-2));

    // zero column count acts as one: a column of ties at the border value
    set_grid(CNT_W'(3), '0);
    repeat (3) send_sample(OUTSIDE_VALUE);

    // a write in mid-grid drops the partial grid
    set_grid(CNT_W'(2), CNT_W'(2));
    send_sample(sample_t'(9));
    send_sample(sample_t'(-9));
    wait_idle();
    write_count(REG_COLUMN_COUNT, cur_cols);
    send_sample(sample_t'(7));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(16'h8000));
    send_sample(sample_t'(7));

    // oversized counts clamp to 32: reach row 31 and column 31
    set_grid(CNT_W'(63), CNT_W'(1));
    send_grid(sb.cells(), FILL_WIDE, '0, -1);
    set_grid(CNT_W'(1), CNT_W'(40));
    send_grid(sb.cells(), FILL_NARROW, '0, -1);

    // flat grid where every cell is a peak while the result side holds off
    set_grid(CNT_W'(2), CNT_W'(4));
    hold_req = 1'b1;
    send_grid(sb.cells(), FILL_FLAT, '0, -1);
    // feed stops mid-grid until every pending peak is out
    send_grid(sb.cells(), FILL_NARROW, '0, 5);

    n = sent + RANDOM_ITEMS;
    while (sent < n) begin
      cols = pick_count();
      rows = pick_count();
      if (sb.clamp_count(rows, MAX_ROWS) * sb.clamp_count(cols, MAX_COLUMNS) > 16)
        rows = CNT_W'($urandom_range(1, 3));
      set_grid(rows, cols);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        total = sb.cells();
        cut = (total > 1 && $urandom_range(0, 5) == 0);
        cnt = cut ? int'($urandom_range(1, total - 1)) : total;
        if (cnt > n - sent) cnt = n - sent;
        if (cnt > 0) begin
          cut = (cnt < total);
          send_grid(cnt, fill_t'($urandom_range(0, 2)),
                    sample_t'($urandom_range(0, 4) - 2), -1);
          if (cut) begin
            wait_idle();
            if ($urandom_range(0, 1)) write_count(REG_ROW_COUNT, cur_rows);
            else write_count(REG_COLUMN_COUNT, cur_cols);
          end
        end
      end
    end

    // closing stretch with both sides running flat out
    set_grid(CNT_W'(2), CNT_W'(3));
    gaps_on = 1'b0;
    send_grid(sb.cells(), FILL_WIDE, '0, -1);
    send_grid(sb.cells(), FILL_NARROW, '0, -1);

    wait_idle();
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
src/glmf_pkg.sv
src/glmf_ctrl.sv
src/glmf_dpath.sv
src/grid_local_maximum_finder.sv
tb/testbench.sv
